// ===== design/differential_drive_odometry_macros.svh =====
// Assertion helpers for the odometry block. They sample on i_clk and are
// switched off while i_rst_n is low.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ddo_pkg.sv =====
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int CFG_BITS      = 32;
    localparam int ANGLE_BITS    = 40;
    localparam int POS_BITS      = 48;
    localparam int DEG_BITS      = 9;

    // Wheel travel: (dr + dl) * distance_per_count is in 2^-25 mm.
    localparam int TRAVEL_BITS   = 40;
    localparam int TRAVEL_SHIFT  = 9;
    localparam int TRAVEL_HALF   = TRAVEL_BITS / 2;

    // CORDIC datapath.
    localparam int ATAN_DEPTH       = 32;
    localparam int ATAN_IDX_BITS    = 5;
    localparam int ATAN_BITS        = 32;
    localparam int ATAN_SCALE_SHIFT = ANGLE_BITS - ATAN_BITS;
    localparam int CS_BITS          = 33;
    localparam int Z_BITS           = ANGLE_BITS + 1;
    localparam logic signed [CS_BITS-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    // Shared multiplier and the exact Q30 scaling.
    localparam int MUL_A_BITS    = CS_BITS;
    localparam int MUL_B_BITS    = TRAVEL_HALF + 1;
    localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS      = PROD_BITS + TRAVEL_HALF;
    localparam int Q30_SHIFT     = 30;
    localparam int DELTA_BITS    = ACC_BITS - Q30_SHIFT;
    localparam int SUM_BITS      = POS_BITS + 1;
    localparam int DEG_PROD_BITS = ANGLE_BITS + DEG_BITS;

    localparam logic [CFG_BITS-1:0] DIST_PER_COUNT_RESET = 32'd287407;
    localparam logic [CFG_BITS-1:0] ANGLE_PER_DIFF_RESET = 32'd11991;
    localparam logic [DEG_BITS-1:0] DEG_PER_TURN         = 9'd360;

    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

    typedef enum logic [0:0] {
        CFG_DISTANCE_PER_COUNT   = 1'b0,
        CFG_ANGLE_PER_COUNT_DIFF = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        QUAD_EAST  = 2'd0,
        QUAD_NORTH = 2'd1,
        QUAD_WEST  = 2'd2,
        QUAD_SOUTH = 2'd3
    } t_quadrant;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [ATAN_BITS-1:0] atan_turn32(input logic [ATAN_IDX_BITS-1:0] idx);
        logic [ATAN_BITS-1:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000000;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ddo_in_if.sv =====
`timescale 1ns / 1ps

interface ddo_in_if;
    import ddo_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] right_count;
    logic [COUNT_BITS-1:0] left_count;

    modport source (output valid, output right_count, output left_count, input ready);
    modport sink (input valid, input right_count, input left_count, output ready);
endinterface

// ===== design/ddo_out_if.sv =====
`timescale 1ns / 1ps

interface ddo_out_if;
    import ddo_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DEG_BITS-1:0] heading_degrees;
    logic signed [POS_BITS-1:0] position_x;
    logic signed [POS_BITS-1:0] position_y;

    modport source (output valid, output heading_degrees, output position_x,
                    output position_y, input ready);
    modport sink (input valid, input heading_degrees, input position_x,
                  input position_y, output ready);
endinterface

// ===== design/differential_drive_odometry.sv =====
`timescale 1ns / 1ps
// Dead-reckoning odometry for a differential-drive base.
// The input channel carries one word per update with the cumulative right and
// left encoder counts. The output channel returns one word per input word with
// the heading in whole degrees and the X and Y positions in 2^-16 mm.
// The two scale registers are written through the plain write port. The user
// must write them only while the block has no word in flight (not enforced).
// An input word is taken only when the sequencer is idle. It then runs the
// heading, travel, CORDIC, rotation, X and Y position and degree steps
// before the result word is loaded into the output register, and no new word
// is taken until then. The pace is set by the CORDIC loop, one iteration per
// cycle, and by the single multiplier, which serves the heading, the travel
// and four partial products of the position update.
// The output register parts the two sides: the next input word is accepted
// while an earlier result still waits, and only the final load waits when the
// receiver stalls with a result still held.
// Reset clears the encoder snapshots, heading and position to zero and loads
// the scale registers with their default values.
`include "differential_drive_odometry_macros.svh"

module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  ddo_pkg::t_cfg_index          i_cfg_index,
    input  logic [ddo_pkg::CFG_BITS-1:0] i_cfg_data,
    ddo_in_if.sink                       i_in,
    ddo_out_if.source                    o_out
);
    import ddo_pkg::*;

    localparam logic [ATAN_IDX_BITS-1:0] ITER_LAST = ATAN_IDX_BITS'(CORDIC_STEPS - 1);
    localparam logic [ANGLE_BITS-1:0] EIGHTH_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 3);
    localparam logic signed [Z_BITS-1:0] Z_EIGHTH = Z_BITS'(1) << (ANGLE_BITS - 3);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_MUL_HEAD = 11'b000_0000_0010,
        S_ADD_HEAD = 11'b000_0000_0100,
        S_TRAVEL   = 11'b000_0000_1000,
        S_CORDIC   = 11'b000_0001_0000,
        S_ROTATE   = 11'b000_0010_0000,
        S_MUL_LO   = 11'b000_0100_0000,
        S_MUL_HI   = 11'b000_1000_0000,
        S_SUM      = 11'b001_0000_0000,
        S_ACC      = 11'b010_0000_0000,
        S_DEG      = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration and architectural state.
    logic [CFG_BITS-1:0]         r_dist_per_count;
    logic [CFG_BITS-1:0]         r_angle_per_diff;
    logic [COUNT_BITS-1:0]       r_prev_right;
    logic [COUNT_BITS-1:0]       r_prev_left;
    logic [ANGLE_BITS-1:0]       r_heading;
    logic signed [POS_BITS-1:0]  r_pos_x;
    logic signed [POS_BITS-1:0]  r_pos_y;

    // Working registers of the sequencer.
    logic signed [COUNT_BITS:0]  r_diff;
    logic [COUNT_BITS:0]         r_sum;
    logic [TRAVEL_BITS-1:0]      r_travel;
    logic signed [CS_BITS-1:0]   r_cx;
    logic signed [CS_BITS-1:0]   r_cy;
    logic signed [Z_BITS-1:0]    r_z;
    logic [ATAN_IDX_BITS-1:0]    r_iter;
    t_quadrant                   r_quad;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic                        r_sin_pass;
    logic [ANGLE_BITS-1:0]       r_habs;
    logic                        r_hneg;

    // Output register.
    logic                        r_out_valid;
    logic signed [DEG_BITS-1:0]  r_out_deg;
    logic signed [POS_BITS-1:0]  r_out_x;
    logic signed [POS_BITS-1:0]  r_out_y;

    logic                        w_accept;
    logic                        w_out_load;
    logic [COUNT_BITS-1:0]       w_dr;
    logic [COUNT_BITS-1:0]       w_dl;
    logic signed [MUL_A_BITS-1:0] w_mul_a;
    logic signed [MUL_B_BITS-1:0] w_mul_b;
    logic signed [PROD_BITS-1:0] w_mul_p;
    logic signed [CS_BITS-1:0]   w_coef;
    logic [ANGLE_BITS-1:0]       w_hround;
    logic [ANGLE_BITS-1:0]       w_resid;
    logic signed [CS_BITS-1:0]   w_dx;
    logic signed [CS_BITS-1:0]   w_dy;
    logic signed [Z_BITS-1:0]    w_atan_z;
    logic signed [DELTA_BITS-1:0] w_delta;
    logic signed [POS_BITS-1:0]  w_pos_cur;
    logic signed [SUM_BITS-1:0]  w_pos_sum;
    logic signed [POS_BITS-1:0]  w_pos_sat;
    logic [DEG_PROD_BITS-1:0]    w_deg_prod;
    logic [DEG_BITS-1:0]         w_deg_mag;
    logic signed [DEG_BITS-1:0]  w_deg;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_DEG) && (!r_out_valid || o_out.ready);

    assign o_out.valid           = r_out_valid;
    assign o_out.heading_degrees = r_out_deg;
    assign o_out.position_x      = r_out_x;
    assign o_out.position_y      = r_out_y;

    // Encoder differences wrap with the counters, so a reversal reads as a
    // large forward step.
    assign w_dr = i_in.right_count - r_prev_right;
    assign w_dl = i_in.left_count - r_prev_left;

    // The one multiplier. Its operands are picked by the current step.
    assign w_coef = r_sin_pass ? r_cy : r_cx;

    always_comb begin
        unique case (r_state)
            S_MUL_HEAD: begin
                w_mul_a = {1'b0, r_angle_per_diff};
                w_mul_b = {{(MUL_B_BITS-COUNT_BITS-1){r_diff[COUNT_BITS]}}, r_diff};
            end
            S_ADD_HEAD: begin
                w_mul_a = {1'b0, r_dist_per_count};
                w_mul_b = {{(MUL_B_BITS-COUNT_BITS-1){1'b0}}, r_sum};
            end
            S_MUL_LO: begin
                w_mul_a = w_coef;
                w_mul_b = {1'b0, r_travel[TRAVEL_HALF-1:0]};
            end
            S_MUL_HI: begin
                w_mul_a = w_coef;
                w_mul_b = {1'b0, r_travel[TRAVEL_BITS-1:TRAVEL_HALF]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Quadrant reduction: the nearest quarter turn and a residual within an
    // eighth of a turn either side.
    assign w_hround = r_heading + EIGHTH_TURN;
    assign w_resid  = r_heading - {w_hround[ANGLE_BITS-1 -: 2], {(ANGLE_BITS-2){1'b0}}};

    // One CORDIC rotation step.
    assign w_dx     = r_cy >>> r_iter;
    assign w_dy     = r_cx >>> r_iter;
    assign w_atan_z = {1'b0, atan_turn32(r_iter), {ATAN_SCALE_SHIFT{1'b0}}};

    // Position update with saturation at the 48-bit limits.
    assign w_delta   = r_acc[ACC_BITS-1:Q30_SHIFT];
    assign w_pos_cur = r_sin_pass ? r_pos_y : r_pos_x;
    assign w_pos_sum = {w_pos_cur[POS_BITS-1], w_pos_cur}
                     + {{(SUM_BITS-DELTA_BITS){w_delta[DELTA_BITS-1]}}, w_delta};

    always_comb begin
        if (w_pos_sum[SUM_BITS-1] != w_pos_sum[POS_BITS-1]) begin
            w_pos_sat = w_pos_sum[SUM_BITS-1] ? POS_MIN : POS_MAX;
        end else begin
            w_pos_sat = w_pos_sum[POS_BITS-1:0];
        end
    end

    // Heading in degrees, truncated toward zero.
    assign w_deg_prod = DEG_PROD_BITS'(r_habs) * DEG_PROD_BITS'(DEG_PER_TURN);
    assign w_deg_mag  = w_deg_prod[DEG_PROD_BITS-1 -: DEG_BITS];
    assign w_deg      = r_hneg ? -w_deg_mag : w_deg_mag;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_accept) n_state = S_MUL_HEAD;
            S_MUL_HEAD: n_state = S_ADD_HEAD;
            S_ADD_HEAD: n_state = S_TRAVEL;
            S_TRAVEL:   n_state = S_CORDIC;
            S_CORDIC:   if (r_iter == ITER_LAST) n_state = S_ROTATE;
            S_ROTATE:   n_state = S_MUL_LO;
            S_MUL_LO:   n_state = S_MUL_HI;
            S_MUL_HI:   n_state = S_SUM;
            S_SUM:      n_state = S_ACC;
            S_ACC:      n_state = r_sin_pass ? S_DEG : S_MUL_LO;
            S_DEG:      if (w_out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_dist_per_count <= DIST_PER_COUNT_RESET;
            r_angle_per_diff <= ANGLE_PER_DIFF_RESET;
            r_prev_right     <= '0;
            r_prev_left      <= '0;
            r_heading        <= '0;
            r_pos_x          <= '0;
            r_pos_y          <= '0;
            r_iter           <= '0;
            r_sin_pass       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DISTANCE_PER_COUNT:   r_dist_per_count <= i_cfg_data;
                    CFG_ANGLE_PER_COUNT_DIFF: r_angle_per_diff <= i_cfg_data;
                endcase
            end

            if (w_accept) begin
                r_prev_right <= i_in.right_count;
                r_prev_left  <= i_in.left_count;
            end

            // The heading wraps modulo one turn.
            if (r_state == S_ADD_HEAD) begin
                r_heading <= r_heading + r_prod[ANGLE_BITS-1:0];
            end

            if (r_state == S_TRAVEL) begin
                r_iter <= '0;
            end else if (r_state == S_CORDIC) begin
                r_iter <= r_iter + 1'b1;
            end

            if (r_state == S_ROTATE) begin
                r_sin_pass <= 1'b0;
            end else if (r_state == S_ACC) begin
                r_sin_pass <= 1'b1;
                if (r_sin_pass) begin
                    r_pos_y <= w_pos_sat;
                end else begin
                    r_pos_x <= w_pos_sat;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_diff <= $signed({1'b0, w_dr}) - $signed({1'b0, w_dl});
            r_sum  <= {1'b0, w_dr} + {1'b0, w_dl};
        end

        unique case (r_state) inside
            S_MUL_HEAD, S_ADD_HEAD, S_MUL_LO: begin
                r_prod <= w_mul_p;
            end
            S_TRAVEL: begin
                r_travel <= r_prod[TRAVEL_SHIFT +: TRAVEL_BITS];
                r_quad   <= t_quadrant'(w_hround[ANGLE_BITS-1 -: 2]);
                r_z      <= {w_resid[ANGLE_BITS-1], w_resid};
                r_cx     <= CORDIC_GAIN_Q30;
                r_cy     <= '0;
            end
            S_CORDIC: begin
                if (!r_z[Z_BITS-1]) begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_z  <= r_z - w_atan_z;
                end else begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_z  <= r_z + w_atan_z;
                end
            end
            S_ROTATE: begin
                // Turn the cosine and sine back by the quadrant taken off.
                case (r_quad)
                    QUAD_EAST: begin
                        r_cx <= r_cx;
                        r_cy <= r_cy;
                    end
                    QUAD_NORTH: begin
                        r_cx <= -r_cy;
                        r_cy <= r_cx;
                    end
                    QUAD_WEST: begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                    end
                    QUAD_SOUTH: begin
                        r_cx <= r_cy;
                        r_cy <= -r_cx;
                    end
                endcase
                r_hneg <= r_heading[ANGLE_BITS-1];
                r_habs <= r_heading[ANGLE_BITS-1] ? -r_heading : r_heading;
            end
            S_MUL_HI: begin
                r_acc  <= {{TRAVEL_HALF{r_prod[PROD_BITS-1]}}, r_prod};
                r_prod <= w_mul_p;
            end
            S_SUM: begin
                r_acc <= r_acc + {r_prod, {TRAVEL_HALF{1'b0}}};
            end
            default: ;
        endcase

        if (w_out_load) begin
            r_out_deg <= w_deg;
            r_out_x   <= r_pos_x;
            r_out_y   <= r_pos_y;
        end
    end

    `DDO_ASSERT_NEXT(a_snapshot_taken, i_in.valid && i_in.ready,
        (r_prev_right == $past(i_in.right_count)) && (r_prev_left == $past(i_in.left_count)),
        "encoder snapshot not taken from the accepted word")
    `DDO_ASSERT_SAME(a_iter_bound, r_state == S_CORDIC, r_iter <= ITER_LAST,
        "CORDIC iteration counter ran past the last step")
    `DDO_ASSERT_SAME(a_residual_range, (r_state == S_CORDIC) && (r_iter == '0),
        (r_z >= -Z_EIGHTH) && (r_z < Z_EIGHTH),
        "quadrant residual outside an eighth of a turn")
    `DDO_ASSERT_SAME(a_degree_range, o_out.valid,
        (o_out.heading_degrees >= -9'sd180) && (o_out.heading_degrees <= 9'sd179),
        "heading in degrees outside one turn")
    `DDO_ASSERT_NEXT(a_result_loaded, w_out_load, o_out.valid && (r_state == S_IDLE),
        "result word not presented after the final step")

endmodule

// ===== sim/odometry_checker.sv =====
`timescale 1ns / 1ps

module odometry_checker #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  ddo_pkg::t_cfg_index          i_cfg_index,
    input  logic [ddo_pkg::CFG_BITS-1:0] i_cfg_data,
    ddo_in_if                            i_in_ch,
    ddo_out_if                           i_out_ch,
    output int                           o_pending,
    output int                           o_failures
);
    import ddo_pkg::*;

    typedef struct packed {
        logic signed [DEG_BITS-1:0] heading_degrees;
        logic signed [POS_BITS-1:0] position_x;
        logic signed [POS_BITS-1:0] position_y;
    } t_pose;

    // Arctangent of 2^-i, in 2^-32 turn.
    localparam logic [0:31][31:0] ARCTAN_TURN = {
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };
    localparam longint UNIT_GAIN_Q30 = 64'sd652032874;
    localparam longint POS_TOP       = longint'(POS_MAX);
    localparam longint POS_BOTTOM    = longint'(POS_MIN);

    logic [CFG_BITS-1:0]   dist_per_count;
    logic [CFG_BITS-1:0]   angle_per_diff;
    logic [COUNT_BITS-1:0] last_right;
    logic [COUNT_BITS-1:0] last_left;
    logic [ANGLE_BITS-1:0] heading;
    longint                pos_x;
    longint                pos_y;
    t_pose                 expected_poses [$];

    // Floor of t * c / 2^30, split so that no product leaves 64 bits.
    function automatic longint mul_q30(input longint t, input longint c);
        longint hi_part;
        longint lo_part;
        hi_part = t >>> 10;
        lo_part = t & 64'sd1023;
        return (hi_part * c + ((lo_part * c) >>> 10)) >>> 20;
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > POS_TOP) return POS_TOP;
        if (v < POS_BOTTOM) return POS_BOTTOM;
        return v;
    endfunction

    // Cosine and sine in Q30: fold to the nearest quadrant, rotate the residual.
    function automatic void unit_vector(input logic [ANGLE_BITS-1:0] angle,
                                        output longint cos_q30, output longint sin_q30);
        logic [ANGLE_BITS:0]   rounded;
        t_quadrant             quad;
        logic [ANGLE_BITS-1:0] residual;
        longint                x;
        longint                y;
        longint                z;
        longint                dx;
        longint                dy;
        longint                step_angle;
        rounded  = {1'b0, angle} + (41'd1 << 37);
        quad     = t_quadrant'(rounded[39:38]);
        residual = angle - {quad, 38'd0};
        z        = $signed(residual);
        x        = UNIT_GAIN_Q30;
        y        = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx         = y >>> i;
            dy         = x >>> i;
            step_angle = {24'd0, ARCTAN_TURN[i], 8'd0};
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - step_angle;
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + step_angle;
            end
        end
        case (quad)
            QUAD_EAST: begin
                cos_q30 = x;
                sin_q30 = y;
            end
            QUAD_NORTH: begin
                cos_q30 = -y;
                sin_q30 = x;
            end
            QUAD_WEST: begin
                cos_q30 = -x;
                sin_q30 = -y;
            end
            default: begin
                cos_q30 = y;
                sin_q30 = -x;
            end
        endcase
    endfunction

    // Advances the pose by one pair of encoder snapshots.
    function automatic t_pose dead_reckon(input logic [COUNT_BITS-1:0] right_now,
                                          input logic [COUNT_BITS-1:0] left_now);
        logic [COUNT_BITS-1:0] d_right;
        logic [COUNT_BITS-1:0] d_left;
        logic [63:0]           turn;
        longint                travel;
        longint                cos_q30;
        longint                sin_q30;
        longint                signed_heading;
        longint                degrees;
        t_pose                 pose;
        d_right    = right_now - last_right;
        d_left     = left_now - last_left;
        last_right = right_now;
        last_left  = left_now;
        turn       = (64'(d_right) - 64'(d_left)) * 64'(angle_per_diff);
        heading    = heading + turn[ANGLE_BITS-1:0];
        travel     = longint'(((64'(d_right) + 64'(d_left)) * 64'(dist_per_count))
                              >> TRAVEL_SHIFT);
        unit_vector(heading, cos_q30, sin_q30);
        pos_x = clamp_pos(pos_x + mul_q30(travel, cos_q30));
        pos_y = clamp_pos(pos_y + mul_q30(travel, sin_q30));
        signed_heading = $signed(heading);
        if (signed_heading < 0) begin
            degrees = -(((-signed_heading) * 360) >>> ANGLE_BITS);
        end else begin
            degrees = (signed_heading * 360) >>> ANGLE_BITS;
        end
        pose.heading_degrees = DEG_BITS'(degrees);
        pose.position_x      = POS_BITS'(pos_x);
        pose.position_y      = POS_BITS'(pos_y);
        return pose;
    endfunction

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            dist_per_count = DIST_PER_COUNT_RESET;
            angle_per_diff = ANGLE_PER_DIFF_RESET;
            last_right     = '0;
            last_left      = '0;
            heading        = '0;
            pos_x          = 0;
            pos_y          = 0;
            expected_poses.delete();
            o_failures     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISTANCE_PER_COUNT:   dist_per_count = i_cfg_data;
                    CFG_ANGLE_PER_COUNT_DIFF: angle_per_diff = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                expected_poses.push_back(dead_reckon(i_in_ch.right_count, i_in_ch.left_count));
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_poses.size() == 0) begin
                    $error("result word arrived with no prediction waiting");
                    o_failures = o_failures + 1;
                end else begin
                    want = expected_poses.pop_front();
                    if (i_out_ch.heading_degrees !== want.heading_degrees) begin
                        $error("heading_degrees: expected %0d, actual %0d",
                               want.heading_degrees, i_out_ch.heading_degrees);
                        o_failures = o_failures + 1;
                    end
                    if (i_out_ch.position_x !== want.position_x) begin
                        $error("position_x: expected %0d, actual %0d",
                               want.position_x, i_out_ch.position_x);
                        o_failures = o_failures + 1;
                    end
                    if (i_out_ch.position_y !== want.position_y) begin
                        $error("position_y: expected %0d, actual %0d",
                               want.position_y, i_out_ch.position_y);
                        o_failures = o_failures + 1;
                    end
                end
            end
        end
        o_pending = expected_poses.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// Top of the odometry testbench. It makes the clock, the reset, the scale
// register writes and the encoder words, and drives the receiver's ready.
// All prediction and comparison live in the checker beside the block; this
// module only reads back how many results are still owed and how many
// mismatches were seen, and gives the verdict.
module testbench;
    import ddo_pkg::*;

    localparam int CORDIC_STEPS  = 20;
    // After the last result we allow twice the time that one word takes for
    // any stray word to surface.
    localparam int SETTLE_CYCLES = 2 * (CORDIC_STEPS + 14);
    // Fewer than 800 words in all, so the limit leaves a wide margin.
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [CFG_BITS-1:0] CFG_MAX = '1;

    // How the two sides of the handshake hold back during a phase.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idling;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_index            cfg_index;
    logic [CFG_BITS-1:0]   cfg_data;
    int                    pending;
    int                    failures;
    int                    cycle_count = 0;
    int                    idle_pct;
    int                    stall_pct;
    // The snapshots most recently sent, so that steps can be made relative.
    logic [COUNT_BITS-1:0] last_right;
    logic [COUNT_BITS-1:0] last_left;

    ddo_in_if  in_ch ();
    ddo_out_if out_ch ();

    differential_drive_odometry #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    odometry_checker #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) checker_inst (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_ch    (in_ch),
        .i_out_ch   (out_ch),
        .o_pending  (pending),
        .o_failures (failures)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver decides afresh at every falling edge whether to stall.
    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one word of absolute snapshots, after a random number of idle
    // cycles, and returns at the falling edge after it has been taken. Valid
    // is left high, so that a following word goes out back to back.
    task automatic send_word(input logic [COUNT_BITS-1:0] right_now,
                             input logic [COUNT_BITS-1:0] left_now);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.right_count <= right_now;
        in_ch.left_count  <= left_now;
        last_right = right_now;
        last_left  = left_now;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Sends a word that moves each wheel by the given number of counts.
    task automatic step_wheels(input logic [COUNT_BITS-1:0] d_right,
                               input logic [COUNT_BITS-1:0] d_left);
        send_word(last_right + d_right, last_left + d_left);
    endtask

    // The scales may only change with nothing in flight, so the input side is
    // closed first and every owed result drained before both registers go in.
    task automatic reconfigure(input logic [CFG_BITS-1:0] distance,
                               input logic [CFG_BITS-1:0] angle);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DISTANCE_PER_COUNT;
        cfg_data  <= distance;
        @(negedge clk);
        cfg_index <= CFG_ANGLE_PER_COUNT_DIFF;
        cfg_data  <= angle;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random word. A straight_pct share are flat-out straight runs, which
    // push the position towards its limits. Most others are plausible motion:
    // small forward steps, with some reversing (which the block reads as a
    // near-full wrap); the rest, arbitrary snapshots, exercise every count bit.
    task automatic send_random_word(input int straight_pct);
        int                    kind;
        logic [COUNT_BITS-1:0] stride;
        if ($urandom_range(99) < straight_pct) begin
            stride = 16'hFFFF - COUNT_BITS'($urandom_range(3));
            step_wheels(stride, stride);
        end else begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                step_wheels(COUNT_BITS'($urandom_range(400)), COUNT_BITS'($urandom_range(400)));
            end else if (kind < 8) begin
                step_wheels(-COUNT_BITS'($urandom_range(400)),
                            -COUNT_BITS'($urandom_range(400)));
            end else begin
                send_word(COUNT_BITS'($urandom), COUNT_BITS'($urandom));
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] distance,
                             input logic [CFG_BITS-1:0] angle,
                             input t_idling idling, input int words,
                             input int straight_pct);
        reconfigure(distance, angle);
        case (idling)
            IDLE_NONE: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                idle_pct  = 66;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                idle_pct  = 0;
                stall_pct = 66;
            end
            default: begin
                idle_pct  = 15;
                stall_pct = 15;
            end
        endcase
        repeat (words) send_random_word(straight_pct);
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_DISTANCE_PER_COUNT;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.right_count = '0;
        in_ch.left_count  = '0;
        out_ch.ready      = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        last_right        = '0;
        last_left         = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words under the reset scales: standing still, a straight
        // step, a gentle left turn, then the right wheel moving backwards,
        // which wraps to a large forward difference.
        send_word(16'd0, 16'd0);
        send_word(16'd100, 16'd100);
        send_word(16'd260, 16'd140);
        send_word(16'd200, 16'd300);
        // Extremes of both counts and alternating bit patterns.
        send_word(16'hFFFF, 16'h0000);
        send_word(16'h0000, 16'hFFFF);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'h5555, 16'hAAAA);
        send_word(16'hAAAA, 16'h5555);

        // At the largest turn rate a difference of 32 counts is just short of
        // an eighth of a turn, so the heading creeps past every quadrant
        // boundary and the half-turn point, then wraps through a full turn.
        reconfigure(CFG_MAX, CFG_MAX);
        repeat (9) step_wheels(16'd32, 16'd0);
        step_wheels(16'd0, 16'd64);
        step_wheels(16'd0, 16'd0);

        // Random phases, each under its own scales and its own idling, with
        // the extremes of both registers among them.
        run_phase(DIST_PER_COUNT_RESET, ANGLE_PER_DIFF_RESET, IDLE_NONE, 120, 10);
        run_phase(CFG_MAX, CFG_MAX, IDLE_SENDER, 100, 10);
        run_phase('0, '0, IDLE_RECEIVER, 80, 10);
        // A long flat-out straight run with the heading frozen drives the
        // position into saturation and keeps it pinned there.
        run_phase(CFG_MAX, '0, IDLE_BOTH, 250, 85);
        run_phase(CFG_BITS'($urandom), CFG_BITS'($urandom), IDLE_NONE, 120, 10);
        run_phase(32'd1, CFG_BITS'($urandom_range(1 << 20)), IDLE_SENDER, 80, 10);

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
